/* rtl/core/stok_pkg.sv */
// Shared types and constants for the s-expression token scanner.
`default_nettype none

package stok_pkg;

   localparam int POSITION_BITS = 16;
   localparam int VALUE_BITS    = 32;

   // Result queue depth; must be a power of two so the pointers wrap freely.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

   typedef enum logic [3:0] {
      KIND_END     = 4'd0,
      KIND_UNTERM  = 4'd1,
      KIND_OPEN    = 4'd2,
      KIND_CLOSE   = 4'd3,
      KIND_QUOTE   = 4'd4,
      KIND_QUASI   = 4'd5,
      KIND_UNQUOTE = 4'd6,
      KIND_SPLICE  = 4'd7,
      KIND_DOT     = 4'd8,
      KIND_INT     = 4'd9,
      KIND_STRING  = 4'd10,
      KIND_SYMBOL  = 4'd11
   } kind_type;

   typedef struct packed {
      kind_type                     kind;
      logic [POSITION_BITS-1:0]     start;
      logic [POSITION_BITS-1:0]     length;
      logic signed [VALUE_BITS-1:0] value;
      logic                         overflow;
      logic                         last;
   } token_type;

   // Up to two tokens per input word, already packed in delivery order.
   typedef struct packed {
      logic      first_valid;
      token_type first;
      logic      second_valid;
      token_type second;
   } emit_type;

endpackage

`default_nettype wire

/* rtl/core/stok_scan_core.sv */
// Lexer state machine: classifies one byte per cycle while go is high and forms its tokens.
`default_nettype none

module stok_scan_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               go,
   input  logic [7:0]         text_byte,
   output stok_pkg::emit_type emit
);
   import stok_pkg::*;

   typedef enum logic [3:0] {
      MODE_IDLE,
      MODE_COMMENT,
      MODE_COMMA,
      MODE_DOT,
      MODE_SIGN,
      MODE_INT,
      MODE_SYMBOL,
      MODE_STRING,
      MODE_ESCAPE
   } mode_type;

   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0a;
   localparam logic [7:0] CH_CR     = 8'h0d;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_QUOTE  = 8'h27;
   localparam logic [7:0] CH_OPEN   = 8'h28;
   localparam logic [7:0] CH_CLOSE  = 8'h29;
   localparam logic [7:0] CH_PLUS   = 8'h2b;
   localparam logic [7:0] CH_COMMA  = 8'h2c;
   localparam logic [7:0] CH_MINUS  = 8'h2d;
   localparam logic [7:0] CH_DOT    = 8'h2e;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_SEMI   = 8'h3b;
   localparam logic [7:0] CH_AT     = 8'h40;
   localparam logic [7:0] CH_BSLASH = 8'h5c;
   localparam logic [7:0] CH_BTICK  = 8'h60;

   localparam int PB = POSITION_BITS;
   localparam int VB = VALUE_BITS;
   localparam int PW = VB + 4;

   mode_type        mode_ff, mode_in;
   logic [PB-1:0]   pos_ff, pos_in;
   logic [PB-1:0]   begin_ff, begin_in;
   logic [VB-1:0]   acc_ff, acc_in;
   logic            neg_ff, neg_in;
   logic            sat_ff, sat_in;

   logic            is_end, blank_byte, is_sep, digit_byte, is_eol;
   logic [PW-1:0]   acc_ext, prod;
   logic [VB-1:0]   limit, dig_acc;
   logic            dig_sat;
   logic            redo;
   logic            a_valid, b_valid;
   token_type       tok_a, tok_b, tok_int, tok_sym;

   function automatic token_type make_token(kind_type kind, logic [PB-1:0] start,
                                            logic [PB-1:0] length);
      token_type t;
      t          = '0;
      t.kind     = kind;
      t.start    = start;
      t.length   = length;
      return t;
   endfunction

   // Character classes.
   assign is_end     = (text_byte == CH_NUL);
   assign is_eol     = (text_byte == CH_CR) || (text_byte == CH_LF);
   assign blank_byte = (text_byte == CH_SPACE) || (text_byte == CH_TAB) || is_eol;
   assign is_sep     = blank_byte || (text_byte == CH_SEMI) || (text_byte == CH_OPEN)
                       || (text_byte == CH_CLOSE) || (text_byte == CH_DQUOTE);
   assign digit_byte = (text_byte >= CH_ZERO) && (text_byte <= CH_NINE);

   // acc*10 + d as two shifts; saturate when the result passes the signed bound.
   assign acc_ext = {4'b0000, acc_ff};
   assign prod    = (acc_ext << 3) + (acc_ext << 1) + PW'(text_byte[3:0]);
   assign limit   = neg_ff ? {1'b1, {(VB-1){1'b0}}} : {1'b0, {(VB-1){1'b1}}};
   assign dig_sat = sat_ff || (prod > {4'b0000, limit});
   assign dig_acc = dig_sat ? limit : prod[VB-1:0];

   always_comb begin
      tok_int          = make_token(KIND_INT, begin_ff, '0);
      tok_int.value    = neg_ff ? $signed(VB'(-acc_ff)) : $signed(acc_ff);
      tok_int.overflow = sat_ff;
      tok_sym          = make_token(KIND_SYMBOL, begin_ff, PB'(pos_ff - begin_ff));
   end

   always_comb begin
      mode_in  = mode_ff;
      pos_in   = pos_ff;
      begin_in = begin_ff;
      acc_in   = acc_ff;
      neg_in   = neg_ff;
      sat_in   = sat_ff;
      redo     = 1'b0;
      a_valid  = 1'b0;
      b_valid  = 1'b0;
      tok_a    = '0;
      tok_b    = '0;

      unique case (mode_ff)
         MODE_COMMENT: begin
            if (is_eol) begin
               mode_in = MODE_IDLE;
            end else if (is_end) begin
               redo = 1'b1;
            end
         end
         MODE_COMMA: begin
            a_valid = 1'b1;
            if (text_byte == CH_AT) begin
               tok_a   = make_token(KIND_SPLICE, begin_ff, '0);
               mode_in = MODE_IDLE;
            end else begin
               tok_a = make_token(KIND_UNQUOTE, begin_ff, '0);
               redo  = 1'b1;
            end
         end
         MODE_DOT: begin
            if (is_sep) begin
               a_valid = 1'b1;
               tok_a   = make_token(KIND_DOT, begin_ff, '0);
               redo    = 1'b1;
            end else if (is_end) begin
               a_valid = 1'b1;
               tok_a   = tok_sym;
               redo    = 1'b1;
            end else begin
               mode_in = MODE_SYMBOL;
            end
         end
         MODE_SIGN, MODE_INT: begin
            if (digit_byte) begin
               mode_in = MODE_INT;
               acc_in  = dig_acc;
               sat_in  = dig_sat;
            end else if (is_sep || is_end) begin
               a_valid = 1'b1;
               tok_a   = (mode_ff == MODE_INT) ? tok_int : tok_sym;
               redo    = 1'b1;
            end else begin
               mode_in = MODE_SYMBOL;
            end
         end
         MODE_SYMBOL: begin
            if (is_sep || is_end) begin
               a_valid = 1'b1;
               tok_a   = tok_sym;
               redo    = 1'b1;
            end
         end
         MODE_STRING: begin
            if (text_byte == CH_DQUOTE) begin
               a_valid = 1'b1;
               tok_a   = make_token(KIND_STRING, PB'(begin_ff + 1'b1),
                                    PB'(pos_ff - begin_ff - 1'b1));
               mode_in = MODE_IDLE;
            end else if (text_byte == CH_BSLASH) begin
               mode_in = MODE_ESCAPE;
            end else if (is_end) begin
               a_valid = 1'b1;
               tok_a   = make_token(KIND_UNTERM, PB'(begin_ff + 1'b1),
                                    PB'(pos_ff - begin_ff - 1'b1));
            end
         end
         MODE_ESCAPE: begin
            // the escaped byte is taken raw; the one after it is examined again
            if (is_end) begin
               a_valid = 1'b1;
               tok_a   = make_token(KIND_UNTERM, PB'(begin_ff + 1'b1),
                                    PB'(pos_ff - begin_ff - 1'b1));
            end else begin
               mode_in = MODE_STRING;
            end
         end
         default: begin
            redo = 1'b1;
         end
      endcase

      // Rescan the byte from idle.
      if (redo) begin
         mode_in = MODE_IDLE;
         if (is_end) begin
            b_valid = 1'b1;
            tok_b   = make_token(KIND_END, pos_ff, '0);
         end else begin
            begin_in = pos_ff;
            acc_in   = '0;
            neg_in   = 1'b0;
            sat_in   = 1'b0;
            if (!blank_byte) begin
               case (text_byte)
                  CH_SEMI:   mode_in = MODE_COMMENT;
                  CH_OPEN:   begin
                     b_valid = 1'b1;
                     tok_b   = make_token(KIND_OPEN, pos_ff, '0);
                  end
                  CH_CLOSE:  begin
                     b_valid = 1'b1;
                     tok_b   = make_token(KIND_CLOSE, pos_ff, '0);
                  end
                  CH_QUOTE:  begin
                     b_valid = 1'b1;
                     tok_b   = make_token(KIND_QUOTE, pos_ff, '0);
                  end
                  CH_BTICK:  begin
                     b_valid = 1'b1;
                     tok_b   = make_token(KIND_QUASI, pos_ff, '0);
                  end
                  CH_COMMA:  mode_in = MODE_COMMA;
                  CH_DOT:    mode_in = MODE_DOT;
                  CH_DQUOTE: mode_in = MODE_STRING;
                  CH_PLUS:   mode_in = MODE_SIGN;
                  CH_MINUS:  begin
                     mode_in = MODE_SIGN;
                     neg_in  = 1'b1;
                  end
                  default: begin
                     if (digit_byte) begin
                        mode_in = MODE_INT;
                        acc_in  = VB'(text_byte[3:0]);
                     end else begin
                        mode_in = MODE_SYMBOL;
                     end
                  end
               endcase
            end
         end
      end

      // End of text drops all state, position included.
      if (is_end) begin
         mode_in  = MODE_IDLE;
         pos_in   = '0;
         begin_in = '0;
         acc_in   = '0;
         neg_in   = 1'b0;
         sat_in   = 1'b0;
      end else begin
         pos_in = PB'(pos_ff + 1'b1);
      end
   end

   // Pack in delivery order and flag the final token of the word.
   always_comb begin
      emit              = '0;
      emit.first_valid  = go && (a_valid || b_valid);
      emit.first        = a_valid ? tok_a : tok_b;
      emit.first.last   = !(a_valid && b_valid);
      emit.second_valid = go && a_valid && b_valid;
      emit.second       = tok_b;
      emit.second.last  = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         pos_ff   <= '0;
         begin_ff <= '0;
         acc_ff   <= '0;
         neg_ff   <= 1'b0;
         sat_ff   <= 1'b0;
      end else if (go) begin
         mode_ff  <= mode_in;
         pos_ff   <= pos_in;
         begin_ff <= begin_in;
         acc_ff   <= acc_in;
         neg_ff   <= neg_in;
         sat_ff   <= sat_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/stok_result_queue.sv */
// Small token queue: takes up to two tokens a cycle, delivers one unless the output stalls.
`default_nettype none

module stok_result_queue (
   input  logic                clock,
   input  logic                reset,
   input  stok_pkg::emit_type  push,
   input  logic                out_stall,
   output logic                head_valid,
   output stok_pkg::token_type head,
   output logic                room
);
   import stok_pkg::*;

   localparam int PTR = QUEUE_PTR_BITS;

   token_type        mem_ff [QUEUE_DEPTH];
   logic [PTR-1:0]   wr_ff, rd_ff;
   logic [PTR:0]     count_ff;
   logic [1:0]       n_push;
   logic             pop;

   assign n_push     = {1'b0, push.first_valid} + {1'b0, push.second_valid};
   assign head_valid = (count_ff != '0);
   assign head       = mem_ff[rd_ff];
   assign pop        = head_valid && !out_stall;
   // Room for a full pair, not counting a word leaving this cycle.
   assign room       = (count_ff <= (PTR+1)'(QUEUE_DEPTH - 2));

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= PTR'(wr_ff + PTR'(n_push));
         rd_ff    <= PTR'(rd_ff + PTR'(pop));
         count_ff <= (PTR+1)'(count_ff + (PTR+1)'(n_push) - (PTR+1)'(pop));
      end
   end

   always_ff @(posedge clock) begin
      if (push.first_valid) begin
         mem_ff[wr_ff] <= push.first;
      end
      if (push.second_valid) begin
         mem_ff[PTR'(wr_ff + 1'b1)] <= push.second;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/sexpr_token_scanner.sv */
// Streaming lexer for Lisp source text: bytes in, tokens out.
//
// Input channel (req_): one source byte per word; a zero byte ends the text.
// Result channel (rsp_): one token per word with kind, start offset, length,
// integer value and overflow flag; rsp_last_result marks the last token a
// given byte produced (a byte yields zero, one or two tokens).
// Tokens that need lookahead (symbols, integers, dot, unquote) come out when
// the byte after them is processed.
// A taken byte sits in the input register, is scanned combinationally and
// its tokens are written into the result queue, whose head is the output.
// Throughput: one byte per cycle while the receiver keeps up; the two tokens
// of a byte leave one at a time through the single output port of the
// four-word result queue. Input stalls while the queue cannot take a pair.
// Reset clears the scanner to idle at position zero and empties the queue.
// When the receiver stalls, the queue fills and req_stall rises; no word is
// lost. The position and all scan state also return to zero after a zero byte.
`default_nettype none

module sexpr_token_scanner (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [7:0]                            req_text_byte,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [3:0]                            rsp_token_kind,
   output logic [stok_pkg::POSITION_BITS-1:0]    rsp_start_offset,
   output logic [stok_pkg::POSITION_BITS-1:0]    rsp_token_length,
   output logic signed [stok_pkg::VALUE_BITS-1:0] rsp_int_result,
   output logic                                  rsp_int_overflow,
   output logic                                  rsp_last_result
);
   import stok_pkg::*;

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       go;
   logic       room;
   emit_type   emit;
   token_type  head;
   kind_type   final_kind;

   assign go        = in_valid_ff && room;
   assign req_stall = in_valid_ff && !room;

   // Hold the byte while the queue is short of space.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_byte_ff <= req_text_byte;
      end
   end

   stok_scan_core u_core (
      .clock     (clock),
      .reset     (reset),
      .go        (go),
      .text_byte (in_byte_ff),
      .emit      (emit)
   );

   stok_result_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (emit),
      .out_stall  (rsp_stall),
      .head_valid (rsp_valid),
      .head       (head),
      .room       (room)
   );

   assign rsp_token_kind   = head.kind;
   assign rsp_start_offset = head.start;
   assign rsp_token_length = head.length;
   assign rsp_int_result   = head.value;
   assign rsp_int_overflow = head.overflow;
   assign rsp_last_result  = head.last;

   assign final_kind = emit.second_valid ? emit.second.kind : emit.first.kind;

   // A zero byte always closes the text with an end or unterminated token.
   a_end_of_text: assert property (@(posedge clock) disable iff (reset)
      (go && (in_byte_ff == 8'h00)) |->
         (emit.first_valid && ((final_kind == KIND_END) || (final_kind == KIND_UNTERM))))
      else $error("zero byte did not close the text");

   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      emit.second_valid |-> (emit.first_valid && !emit.first.last))
      else $error("second token without a leading first token");

   a_empty_room: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled while the result queue is empty");

endmodule

`default_nettype wire

/* dv/testbench.sv */
// Self-checking testbench for the s-expression token scanner.
`timescale 1ns / 100ps

module testbench;
   import stok_pkg::*;

   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_LF        = 8'h0A;
   localparam logic [7:0] CH_CR        = 8'h0D;
   localparam logic [7:0] CH_BACKQUOTE = 8'h60;
   localparam int MARK_PAUSE  = 256;
   localparam int MARK_IDLING = 512;

   typedef enum logic [3:0] {
      SCAN_IDLE, SCAN_COMMENT, SCAN_COMMA, SCAN_DOT, SCAN_SIGN,
      SCAN_INT, SCAN_SYMBOL, SCAN_STRING, SCAN_ESCAPE
   } scan_state_type;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic [7:0] req_text_byte = 8'd0;
   logic rsp_stall = 1'b0;
   logic req_stall;
   logic rsp_valid;
   logic [3:0] rsp_token_kind;
   logic [POSITION_BITS-1:0] rsp_start_offset;
   logic [POSITION_BITS-1:0] rsp_token_length;
   logic signed [VALUE_BITS-1:0] rsp_int_result;
   logic rsp_int_overflow;
   logic rsp_last_result;

   // Byte values 0..255, or pause / idling-profile markers.
   int source_bytes[$];
   token_type pending_tokens[$];
   int mismatch_count = 0;
   int send_wait = 0;
   int stall_left = 0;
   int send_gap_max = 0;
   int stall_gap_max = 0;

   // Lexer shadow state
   scan_state_type scan_state;
   logic [POSITION_BITS-1:0] scan_pos;
   logic [POSITION_BITS-1:0] tok_begin;
   logic [63:0] magnitude;
   logic negative;
   logic saturated;
   token_type byte_tokens[2];
   int byte_token_count;

   string int_edges[5] = '{"2147483647", "2147483648", "-2147483648",
                           "-2147483649", "99999999999"};
   int gap_choice[3] = '{0, 3, 15};

   sexpr_token_scanner dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_text_byte(req_text_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_token_kind(rsp_token_kind),
      .rsp_start_offset(rsp_start_offset),
      .rsp_token_length(rsp_token_length),
      .rsp_int_result(rsp_int_result),
      .rsp_int_overflow(rsp_int_overflow),
      .rsp_last_result(rsp_last_result)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("Regression FAIL");
      $finish;
   end

   function automatic logic blank_char(input logic [7:0] b);
      return b == " " || b == CH_TAB || b == CH_CR || b == CH_LF;
   endfunction

   function automatic logic is_separator(input logic [7:0] b);
      return blank_char(b) || b == ";" || b == "(" || b == ")" || b == "\"";
   endfunction

   function automatic logic digit_char(input logic [7:0] b);
      return b >= "0" && b <= "9";
   endfunction

   function automatic void clear_scan();
      scan_state = SCAN_IDLE;
      scan_pos   = '0;
      tok_begin  = '0;
      magnitude  = '0;
      negative   = 1'b0;
      saturated  = 1'b0;
   endfunction

   // Saturate at the signed bound that matches the sign seen so far.
   function automatic void add_digit(input logic [7:0] b);
      logic [63:0] digit;
      logic [63:0] bound;
      digit = 64'(b) - 64'h30;
      bound = (64'd1 << (VALUE_BITS - 1)) - (negative ? 64'd0 : 64'd1);
      if (saturated || magnitude > (bound - digit) / 10) begin
         magnitude = bound;
         saturated = 1'b1;
      end else begin
         magnitude = magnitude * 10 + digit;
      end
   endfunction

   function automatic void emit_token(input kind_type kind,
                                      input logic [POSITION_BITS-1:0] start,
                                      input logic [POSITION_BITS-1:0] len,
                                      input logic [VALUE_BITS-1:0] value,
                                      input logic ovf);
      token_type t;
      t.kind     = kind;
      t.start    = start;
      t.length   = len;
      t.value    = value;
      t.overflow = ovf;
      t.last     = 1'b0;
      byte_tokens[byte_token_count] = t;
      byte_token_count++;
   endfunction

   function automatic void lex_byte(input logic [7:0] b);
      logic rescan;
      logic [63:0] signed_value;
      rescan = 1'b0;
      byte_token_count = 0;
      case (scan_state)
         SCAN_COMMENT: begin
            if (b == CH_CR || b == CH_LF) scan_state = SCAN_IDLE;
            else if (b == 8'd0) rescan = 1'b1;
         end
         SCAN_COMMA: begin
            if (b == "@") begin
               emit_token(KIND_SPLICE, tok_begin, '0, '0, 1'b0);
               scan_state = SCAN_IDLE;
            end else begin
               emit_token(KIND_UNQUOTE, tok_begin, '0, '0, 1'b0);
               rescan = 1'b1;
            end
         end
         SCAN_DOT: begin
            if (is_separator(b)) begin
               emit_token(KIND_DOT, tok_begin, '0, '0, 1'b0);
               rescan = 1'b1;
            end else if (b == 8'd0) begin
               emit_token(KIND_SYMBOL, tok_begin, scan_pos - tok_begin, '0, 1'b0);
               rescan = 1'b1;
            end else begin
               scan_state = SCAN_SYMBOL;
            end
         end
         SCAN_SIGN: begin
            if (digit_char(b)) begin
               scan_state = SCAN_INT;
               add_digit(b);
            end else if (is_separator(b) || b == 8'd0) begin
               emit_token(KIND_SYMBOL, tok_begin, scan_pos - tok_begin, '0, 1'b0);
               rescan = 1'b1;
            end else begin
               scan_state = SCAN_SYMBOL;
            end
         end
         SCAN_INT: begin
            if (digit_char(b)) begin
               add_digit(b);
            end else if (is_separator(b) || b == 8'd0) begin
               signed_value = negative ? 64'd0 - magnitude : magnitude;
               emit_token(KIND_INT, tok_begin, '0, signed_value[VALUE_BITS-1:0], saturated);
               rescan = 1'b1;
            end else begin
               scan_state = SCAN_SYMBOL;
            end
         end
         SCAN_SYMBOL: begin
            if (is_separator(b) || b == 8'd0) begin
               emit_token(KIND_SYMBOL, tok_begin, scan_pos - tok_begin, '0, 1'b0);
               rescan = 1'b1;
            end
         end
         SCAN_STRING: begin
            if (b == "\"") begin
               emit_token(KIND_STRING, tok_begin + 1'b1, scan_pos - tok_begin - 1'b1,
                          '0, 1'b0);
               scan_state = SCAN_IDLE;
            end else if (b == "\\") begin
               scan_state = SCAN_ESCAPE;
            end else if (b == 8'd0) begin
               emit_token(KIND_UNTERM, tok_begin + 1'b1, scan_pos - tok_begin - 1'b1,
                          '0, 1'b0);
            end
         end
         SCAN_ESCAPE: begin
            if (b == 8'd0)
               emit_token(KIND_UNTERM, tok_begin + 1'b1, scan_pos - tok_begin - 1'b1,
                          '0, 1'b0);
            else
               scan_state = SCAN_STRING;
         end
         default: rescan = 1'b1;
      endcase

      // Examine the byte again as the start of a new token.
      if (rescan) begin
         scan_state = SCAN_IDLE;
         if (b == 8'd0) begin
            emit_token(KIND_END, scan_pos, '0, '0, 1'b0);
         end else begin
            tok_begin = scan_pos;
            magnitude = '0;
            negative  = 1'b0;
            saturated = 1'b0;
            if (blank_char(b)) begin
            end else if (b == CH_BACKQUOTE) begin
               emit_token(KIND_QUASI, scan_pos, '0, '0, 1'b0);
            end else begin
               case (b)
                  ";":  scan_state = SCAN_COMMENT;
                  "(":  emit_token(KIND_OPEN, scan_pos, '0, '0, 1'b0);
                  ")":  emit_token(KIND_CLOSE, scan_pos, '0, '0, 1'b0);
                  "'":  emit_token(KIND_QUOTE, scan_pos, '0, '0, 1'b0);
                  ",":  scan_state = SCAN_COMMA;
                  ".":  scan_state = SCAN_DOT;
                  "\"": scan_state = SCAN_STRING;
                  "+":  scan_state = SCAN_SIGN;
                  "-": begin
                     scan_state = SCAN_SIGN;
                     negative = 1'b1;
                  end
                  default: begin
                     if (digit_char(b)) begin
                        scan_state = SCAN_INT;
                        add_digit(b);
                     end else begin
                        scan_state = SCAN_SYMBOL;
                     end
                  end
               endcase
            end
         end
      end

      if (b == 8'd0) clear_scan();
      else scan_pos = scan_pos + 1'b1;

      for (int i = 0; i < byte_token_count; i++) begin
         if (i == byte_token_count - 1) byte_tokens[i].last = 1'b1;
         pending_tokens.push_back(byte_tokens[i]);
      end
   endfunction

   function automatic void push_text(input string s);
      for (int i = 0; i < s.len(); i++) source_bytes.push_back(s[i]);
   endfunction

   // One text of random tokens, mostly well formed, closed by a zero byte.
   function automatic void add_random_text();
      int token_total;
      int c;
      token_total = $urandom_range(0, 12);
      for (int t = 0; t < token_total; t++) begin
         case ($urandom_range(0, 11))
            0: push_text("(");
            1: push_text(")");
            2: push_text("'");
            3: source_bytes.push_back(CH_BACKQUOTE);
            4: push_text(",");
            5: push_text(",@");
            6: push_text(".");
            7: begin
               if ($urandom_range(0, 5) == 0) begin
                  push_text(int_edges[$urandom_range(0, 4)]);
               end else begin
                  c = $urandom_range(0, 3);
                  if (c == 1) push_text("+");
                  else if (c == 2) push_text("-");
                  repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? 12 : 4))
                     source_bytes.push_back(48 + $urandom_range(0, 9));
               end
            end
            8: begin
               push_text("\"");
               repeat ($urandom_range(0, 6)) begin
                  if ($urandom_range(0, 3) == 0) begin
                     push_text("\\");
                     source_bytes.push_back($urandom_range(1, 255));
                  end else begin
                     do c = $urandom_range(1, 255); while (c == "\"" || c == "\\");
                     source_bytes.push_back(c);
                  end
               end
               push_text("\"");
            end
            9: begin
               repeat ($urandom_range(1, 6)) begin
                  do c = $urandom_range(1, 255); while (is_separator(8'(c)));
                  source_bytes.push_back(c);
               end
            end
            10: begin
               push_text(";");
               repeat ($urandom_range(0, 5)) begin
                  do c = $urandom_range(1, 255); while (c == CH_LF || c == CH_CR);
                  source_bytes.push_back(c);
               end
               if ($urandom_range(0, 3) != 0)
                  source_bytes.push_back(($urandom_range(0, 1) == 0) ? CH_LF : CH_CR);
            end
            default: begin
               repeat ($urandom_range(1, 4)) source_bytes.push_back($urandom_range(1, 255));
            end
         endcase
         case ($urandom_range(0, 5))
            0: ;
            1: source_bytes.push_back(CH_TAB);
            2: source_bytes.push_back(CH_CR);
            3: source_bytes.push_back(CH_LF);
            default: push_text(" ");
         endcase
      end
      // Occasionally cut the text inside a string or right after a backslash.
      if ($urandom_range(0, 9) == 0) begin
         if ($urandom_range(0, 1) == 0) push_text("\"ab");
         else push_text("\"a\\");
      end
      source_bytes.push_back(0);
   endfunction

   always @(posedge clock) begin : drive_words
      int marker;
      if (reset) begin
         req_valid <= 1'b0;
         send_wait <= 0;
         clear_scan();
      end else begin
         if (req_valid && !req_stall) lex_byte(req_text_byte);
         // Hold a stalled word; otherwise advance.
         if (!req_valid || !req_stall) begin
            if (send_wait > 0) begin
               req_valid <= 1'b0;
               send_wait <= send_wait - 1;
            end else if (source_bytes.size() == 0) begin
               req_valid <= 1'b0;
            end else if (source_bytes[0] == MARK_PAUSE) begin
               req_valid <= 1'b0;
               if (pending_tokens.size() == 0) void'(source_bytes.pop_front());
            end else if (source_bytes[0] >= MARK_IDLING) begin
               req_valid <= 1'b0;
               marker = source_bytes.pop_front() - MARK_IDLING;
               send_gap_max  <= marker / 16;
               stall_gap_max <= marker % 16;
            end else begin
               req_valid     <= 1'b1;
               req_text_byte <= 8'(source_bytes.pop_front());
               send_wait     <= $urandom_range(0, send_gap_max);
            end
         end
      end
   end

   task automatic check_field(input string field_name, input logic [31:0] want_value,
                              input logic [31:0] got_value);
      if (want_value !== got_value) begin
         $display("%0t: %s mismatch: expected %0h, got %0h", $time, field_name,
                  want_value, got_value);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : watch_tokens
      token_type want;
      int wait_n;
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else begin
         wait_n = stall_left;
         if (rsp_valid && !rsp_stall) begin
            if (pending_tokens.size() == 0) begin
               $display("%0t: token word with none expected: expected nothing, got kind %0d",
                        $time, rsp_token_kind);
               mismatch_count++;
            end else begin
               want = pending_tokens.pop_front();
               check_field("token_kind", want.kind, rsp_token_kind);
               check_field("start_offset", want.start, rsp_start_offset);
               check_field("token_length", want.length, rsp_token_length);
               check_field("int_result", want.value, rsp_int_result);
               check_field("int_overflow", want.overflow, rsp_int_overflow);
               check_field("last_result", want.last, rsp_last_result);
            end
            wait_n = $urandom_range(0, stall_gap_max);
         end
         if (wait_n > 0) begin
            rsp_stall  <= 1'b1;
            stall_left <= wait_n - 1;
         end else begin
            rsp_stall  <= 1'b0;
            stall_left <= 0;
         end
      end
   end

   initial begin : run_regression
      int start_size;
      // Directed: every token kind, escapes, saturation, cut strings.
      source_bytes.push_back(0);
      push_text("(a 'b");
      source_bytes.push_back(CH_BACKQUOTE);
      push_text("c,d,@e . x)");
      source_bytes.push_back(0);
      push_text("\"a\\\"\"z;c");
      source_bytes.push_back(CH_LF);
      push_text("-5 + 2147483648 -2147483649 12a");
      source_bytes.push_back(255);
      push_text(" .");
      source_bytes.push_back(0);
      push_text("\"ab");
      source_bytes.push_back(0);
      push_text("\"a\\");
      source_bytes.push_back(0);
      push_text(",");
      source_bytes.push_back(0);
      source_bytes.push_back(MARK_PAUSE);

      // Random texts under changing idle profiles.
      source_bytes.push_back(MARK_IDLING + 15 * 16 + 15);
      start_size = source_bytes.size();
      while (source_bytes.size() - start_size < 830) begin
         if ($urandom_range(0, 3) == 0)
            source_bytes.push_back(MARK_IDLING + 16 * gap_choice[$urandom_range(0, 2)]
                                   + gap_choice[$urandom_range(0, 2)]);
         add_random_text();
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (source_bytes.size() != 0 || req_valid || pending_tokens.size() != 0)
         @(posedge clock);
      repeat (16) @(posedge clock);
      if (mismatch_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

/* filelist.f */
rtl/core/stok_pkg.sv
rtl/core/stok_scan_core.sv
rtl/core/stok_result_queue.sv
rtl/core/sexpr_token_scanner.sv
dv/testbench.sv
